/* hdl/rcf_pkg.sv */
`timescale 1ns / 1ps

package rcf_pkg;

  // Pixel as packed in the line stores: red in the low byte
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // 3x3 window, [row][column], row 0 on top, column 0 on the left
  typedef pixel_t [2:0][2:0] window_t;

  // Kernel rows, [0] top; each row holds left coefficient in bits 7:0
  typedef logic [2:0][23:0] kernel_t;

  // Position and flags that travel with a window through the arithmetic
  typedef struct packed {
    logic [9:0] column;
    logic [9:0] row;
    logic       done;
  } tag_t;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_KERNEL_TOP    = 3'd0,
    REG_KERNEL_MIDDLE = 3'd1,
    REG_KERNEL_BOTTOM = 3'd2,
    REG_LINE_WIDTH    = 3'd3,
    REG_FRAME_HEIGHT  = 3'd4
  } reg_index_t;

  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned SIZE_W     = 11;

  // Reset values: edge kernel, VGA frame
  localparam logic [23:0] KERNEL_TOP_RESET    = 24'hFFFFFF;
  localparam logic [23:0] KERNEL_MIDDLE_RESET = 24'hFF08FF;
  localparam logic [23:0] KERNEL_BOTTOM_RESET = 24'hFFFFFF;
  localparam logic [10:0] LINE_WIDTH_RESET    = 11'd640;
  localparam logic [10:0] FRAME_HEIGHT_RESET  = 11'd480;

  // Smallest frame dimension
  localparam int unsigned MIN_SIZE = 3;

  // Product 9x8 signed -> 17 bits; three of them -> 19; nine -> 21
  localparam int unsigned PROD_W = 17;
  localparam int unsigned PSUM_W = 19;
  localparam int unsigned SUM_W  = 21;

  localparam logic [7:0] PIX_MAX = 8'd255;

endpackage

/* hdl/rgb_conv3x3_filter.sv */
`timescale 1ns / 1ps

// Streaming 3x3 convolution over an RGB raster. One pixel is accepted per
// clock when out_stall is low; the pipeline is three stages deep (pixel with
// its position and the line-store read, partial sums, output register).
// Throughput is one pixel per cycle while out_stall is low: each line-store
// RAM takes one read and one write per pixel. Only interior pixels give a
// result, tagged with its row, column and a flag on the last one of the
// frame. Width and height are clamped to 3..MAX_WIDTH / 3..MAX_HEIGHT;
// configuration must be written while the pipeline is empty. The line stores
// have no reset: the first two lines of a frame fill them before any result
// uses them.
module rgb_conv3x3_filter #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration
  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_index,
  input  logic [rcf_pkg::CFG_DATA_W-1:0] cfg_data,
  // Pixel input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  pixel_red,
  input  logic [7:0]  pixel_green,
  input  logic [7:0]  pixel_blue,
  input  logic        frame_start,
  // Result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [9:0]  out_column,
  output logic [9:0]  out_row,
  output logic        frame_done
);

  import rcf_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned AW = $clog2(MAX_WIDTH);

  // Configuration registers
  kernel_t            kern;
  logic [SIZE_W-1:0]  line_width;
  logic [SIZE_W-1:0]  frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      kern[0]      <= KERNEL_TOP_RESET;
      kern[1]      <= KERNEL_MIDDLE_RESET;
      kern[2]      <= KERNEL_BOTTOM_RESET;
      line_width   <= LINE_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_KERNEL_TOP:    kern[0]      <= cfg_data;
        REG_KERNEL_MIDDLE: kern[1]      <= cfg_data;
        REG_KERNEL_BOTTOM: kern[2]      <= cfg_data;
        REG_LINE_WIDTH:    line_width   <= cfg_data[SIZE_W-1:0];
        REG_FRAME_HEIGHT:  frame_height <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size, clamped to the supported range
  logic [CW-1:0] width_eff;
  logic [RW-1:0] height_eff;

  always_comb begin
    if (32'(line_width) < MIN_SIZE) begin
      width_eff = CW'(MIN_SIZE);
    end else if (32'(line_width) > MAX_WIDTH) begin
      width_eff = CW'(MAX_WIDTH);
    end else begin
      width_eff = CW'(line_width);
    end
    if (32'(frame_height) < MIN_SIZE) begin
      height_eff = RW'(MIN_SIZE);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      height_eff = RW'(MAX_HEIGHT);
    end else begin
      height_eff = RW'(frame_height);
    end
  end

  // Handshake
  logic valid1;
  logic win_ready;
  logic accept;
  logic adv1;

  assign in_stall = valid1 && !win_ready;
  assign accept   = in_valid && !in_stall;
  assign adv1     = valid1 && win_ready;

  // Position counters
  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] col_cur;
  logic [RW-1:0] row_cur;
  logic [CW-1:0] col_inc;
  logic [RW-1:0] row_inc;
  logic [CW-1:0] column_count_next;
  logic [RW-1:0] row_count_next;

  always_comb begin
    // Position of the incoming pixel
    col_cur = frame_start ? '0 : column_count;
    row_cur = frame_start ? '0 : row_count;
    if (col_cur >= width_eff) begin
      col_cur = '0;
      row_cur = row_cur + 1'b1;
    end
    if (row_cur >= height_eff) begin
      row_cur = '0;
    end
    // Position of the next pixel
    col_inc = col_cur + 1'b1;
    row_inc = row_cur + 1'b1;
    if (col_inc >= width_eff) begin
      column_count_next = '0;
      row_count_next    = (row_inc >= height_eff) ? '0 : row_inc;
    end else begin
      column_count_next = col_inc;
      row_count_next    = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Stage 1: pixel and position, line-store read in flight
  pixel_t        pix0;
  pixel_t        pix1;
  logic [AW-1:0] addr0;
  logic [AW-1:0] addr1;
  logic          prod1;
  tag_t          tag1;

  assign pix0  = '{blue: pixel_blue, green: pixel_green, red: pixel_red};
  assign addr0 = col_cur[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (accept) begin
      valid1 <= 1'b1;
    end else if (adv1) begin
      valid1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix1       <= pix0;
      addr1      <= addr0;
      prod1      <= (32'(row_cur) >= 2) && (32'(col_cur) >= 2);
      tag1.column <= 10'(32'(col_cur) - 1);
      tag1.row    <= 10'(32'(row_cur) - 1);
      tag1.done   <= (32'(row_cur) == 32'(height_eff) - 1) &&
                     (32'(col_cur) == 32'(width_eff) - 1);
    end
  end

  // Line stores: a holds the line above, b the line two above
  pixel_t mid;
  pixel_t top;

  rcf_ram #(
    .WIDTH ($bits(pixel_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_store_a (
    .clk     (clk),
    .wr_en   (adv1),
    .wr_addr (addr1),
    .wr_data (pix1),
    .rd_en   (accept),
    .rd_addr (addr0),
    .rd_data (mid)
  );

  rcf_ram #(
    .WIDTH ($bits(pixel_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_store_b (
    .clk     (clk),
    .wr_en   (adv1),
    .wr_addr (addr1),
    .wr_data (mid),
    .rd_en   (accept),
    .rd_addr (addr0),
    .rd_data (top)
  );

  // Window: two previous columns of the three lines
  pixel_t  window_regs [6];
  window_t win;

  always_comb begin
    win[0][0] = window_regs[0];
    win[0][1] = window_regs[1];
    win[0][2] = top;
    win[1][0] = window_regs[2];
    win[1][1] = window_regs[3];
    win[1][2] = mid;
    win[2][0] = window_regs[4];
    win[2][1] = window_regs[5];
    win[2][2] = pix1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        window_regs[i] <= '0;
      end
    end else if (adv1) begin
      window_regs[0] <= window_regs[1];
      window_regs[1] <= top;
      window_regs[2] <= window_regs[3];
      window_regs[3] <= mid;
      window_regs[4] <= window_regs[5];
      window_regs[5] <= pix1;
    end
  end

  // Arithmetic and output register
  rcf_kernel u_kernel (
    .clk        (clk),
    .rst        (rst),
    .win_valid  (valid1 && prod1),
    .win_ready  (win_ready),
    .win        (win),
    .kern       (kern),
    .tag        (tag1),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_column (out_column),
    .out_row    (out_row),
    .frame_done (frame_done)
  );

endmodule

/* hdl/rcf_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port RAM, one write port, one registered read port
module rcf_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/rcf_kernel.sv */
`timescale 1ns / 1ps

// Two-stage 3x3 multiply-accumulate with clamp and output register
module rcf_kernel (
  input  logic            clk,
  input  logic            rst,
  input  logic            win_valid,
  output logic            win_ready,
  input  rcf_pkg::window_t win,
  input  rcf_pkg::kernel_t kern,
  input  rcf_pkg::tag_t    tag,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue,
  output logic [9:0]      out_column,
  output logic [9:0]      out_row,
  output logic            frame_done
);

  import rcf_pkg::*;

  logic                     valid2;
  tag_t                     tag2;
  logic signed [PSUM_W-1:0] psum      [3][3];
  logic signed [PSUM_W-1:0] psum_next [3][3];
  logic signed [SUM_W-1:0]  sum       [3];
  logic [7:0]               clamped   [3];
  logic                     ld2;
  logic                     ld3;

  // Stage handshake: output register frees, then partial-sum stage
  assign ld3       = !out_valid || !out_stall;
  assign ld2       = !valid2 || ld3;
  assign win_ready = ld2;

  // Per channel, per kernel row: sum of three products
  always_comb begin
    logic signed [PROD_W-1:0] prod;
    logic signed [PSUM_W-1:0] acc;
    logic [7:0]               chan;
    logic signed [7:0]        coef;
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        acc = '0;
        for (int k = 0; k < 3; k++) begin
          chan = win[r][k][8*ch +: 8];
          coef = signed'(kern[r][8*k +: 8]);
          prod = $signed({1'b0, chan}) * coef;
          acc  = acc + PSUM_W'(prod);
        end
        psum_next[ch][r] = acc;
      end
    end
  end

  // Partial-sum stage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (ld2) begin
      valid2 <= win_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2 && win_valid) begin
      psum <= psum_next;
      tag2 <= tag;
    end
  end

  // Final sum and clamp to 0..255
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = SUM_W'(psum[ch][0]) + SUM_W'(psum[ch][1]) + SUM_W'(psum[ch][2]);
      if (sum[ch] < 0) begin
        clamped[ch] = '0;
      end else if (sum[ch] > SUM_W'(signed'({1'b0, PIX_MAX}))) begin
        clamped[ch] = PIX_MAX;
      end else begin
        clamped[ch] = sum[ch][7:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld3) begin
      out_valid <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (ld3 && valid2) begin
      out_red    <= clamped[0];
      out_green  <= clamped[1];
      out_blue   <= clamped[2];
      out_column <= tag2.column;
      out_row    <= tag2.row;
      frame_done <= tag2.done;
    end
  end

endmodule
